// File: hw/rtl/mwos_pkg.sv
package mwos_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         size_code;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic load;
    logic check;
    logic wr;
    logic rd;
    logic capt;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic do_push;
    logic do_read;
    logic last;
  } sts_t;

endpackage

// File: hw/rtl/mwos_ctrl.sv
module mwos_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mwos_pkg::sts_t  sts_i,
  output mwos_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CAPT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.do_push) begin
          state_d = S_WRITE;
        end else if (sts_i.do_read) begin
          state_d = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.capt = 1'b1;
        state_d    = sts_i.last ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hw/rtl/mwos_datapath.sv
module mwos_datapath #(
  parameter int STACK_DEPTH_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mwos_pkg::in_t  in_i,
  input  mwos_pkg::cmd_t cmd_i,
  output mwos_pkg::sts_t sts_o,
  output mwos_pkg::out_t out_o
);

  localparam int AW = $clog2(STACK_DEPTH_BYTES);
  localparam int PW = $clog2(STACK_DEPTH_BYTES + 1);
  localparam logic [PW:0] DEPTH_L = (PW + 1)'(STACK_DEPTH_BYTES);

  logic [7:0]    mem [STACK_DEPTH_BYTES];

  logic [1:0]    func_q, size_q;
  logic [31:0]   val_q, acc_q;
  logic [1:0]    cnt_q;
  logic [PW-1:0] sp_q;
  logic [1:0]    st_q;
  logic          rdok_q;
  logic [7:0]    rdata_q;
  mwos_pkg::out_t out_q;

  logic [2:0]    nb;
  logic          is_push, is_read, ovf, unf, last;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   ext;

  always_comb begin
    unique case (size_q)
      mwos_pkg::SZ_BYTE: nb = 3'd1;
      mwos_pkg::SZ_HALF: nb = 3'd2;
      mwos_pkg::SZ_WORD: nb = 3'd4;
      default:           nb = 3'd0;
    endcase
  end

  assign is_push = (nb != 3'd0) && (func_q == mwos_pkg::OP_PUSH);
  assign is_read = (nb != 3'd0) &&
                   ((func_q == mwos_pkg::OP_POP) || (func_q == mwos_pkg::OP_PEEK));
  assign ovf     = ({1'b0, sp_q} + (PW + 1)'(nb)) > DEPTH_L;
  assign unf     = sp_q < PW'(nb);
  assign last    = cnt_q == 2'(nb - 3'd1);

  assign sts_o.do_push = is_push && !ovf;
  assign sts_o.do_read = is_read && !unf;
  assign sts_o.last    = last;

  assign waddr = AW'(sp_q + PW'(cnt_q));
  assign raddr = AW'(sp_q - PW'(cnt_q) - PW'(1));

  always_comb begin
    unique case (size_q)
      mwos_pkg::SZ_BYTE: ext = {{24{acc_q[7]}}, acc_q[7:0]};
      mwos_pkg::SZ_HALF: ext = {{16{acc_q[15]}}, acc_q[15:0]};
      default:           ext = acc_q;
    endcase
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[waddr] <= val_q[7:0] & mwos_pkg::BYTE_MASK;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.check) begin
        cnt_q <= '0;
      end else if (cmd_i.wr || cmd_i.capt) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (cmd_i.wr && last) begin
        sp_q <= sp_q + PW'(nb);
      end else if (cmd_i.finish && rdok_q && (func_q == mwos_pkg::OP_POP)) begin
        sp_q <= sp_q - PW'(nb);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_i.func;
      size_q <= in_i.size_code;
      val_q  <= in_i.push_value;
    end else if (cmd_i.wr) begin
      val_q <= val_q >> 8;
    end
    if (cmd_i.check) begin
      acc_q  <= '0;
      rdok_q <= is_read && !unf;
      if (is_push && ovf) begin
        st_q <= mwos_pkg::ST_OVERFLOW;
      end else if (is_read && unf) begin
        st_q <= mwos_pkg::ST_UNDERFLOW;
      end else begin
        st_q <= mwos_pkg::ST_OK;
      end
    end else if (cmd_i.capt) begin
      acc_q <= {acc_q[23:0], rdata_q};
    end
    if (cmd_i.finish) begin
      out_q.read_value <= rdok_q ? ext : 32'd0;
      out_q.status     <= st_q;
    end
  end

  assign out_o = out_q;

endmodule

// File: hw/rtl/multi_width_operand_stack.sv
// push of n bytes: after accept, a check state, then the bytes written one by one in the write state, then done
// pop or peek of n bytes: after accept, a check state, then read and capture states in turn per byte, then done
// failing or ignored request: after accept, a check state, then the done state
// a new request is taken only after the done state issues the result; the stack memory moves one byte at a time
// reset clears the stack pointer and the result flag; memory contents are not cleared
module multi_width_operand_stack #(
  parameter int STACK_DEPTH_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mwos_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mwos_pkg::out_t out_o
);

  mwos_pkg::cmd_t cmd;
  mwos_pkg::sts_t sts;

  mwos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mwos_datapath #(
    .STACK_DEPTH_BYTES (STACK_DEPTH_BYTES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != mwos_pkg::ST_OK) |-> out_o.read_value == 32'sd0)
    else $error("failed request returned nonzero word");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.check, cmd.wr, cmd.rd, cmd.capt, cmd.finish}))
    else $error("more than one datapath command");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_valid_o || out_ready_i)
    else $error("pending result overwritten");

endmodule
